[rtl/torus_point_zbuffer_plot_macros.svh]
// ----------------------------------------------------------------------------
// torus_point_zbuffer_plot_macros.svh
// Assertion helpers shared by the plotter RTL.
// ----------------------------------------------------------------------------
`ifndef TORUS_POINT_ZBUFFER_PLOT_MACROS_SVH
`define TORUS_POINT_ZBUFFER_PLOT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define TPZ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define TPZ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/tpz_pkg.sv]
// ----------------------------------------------------------------------------
// tpz_pkg
// Types, codes and the micro-op table of the torus point plotter.
// ----------------------------------------------------------------------------
package tpz_pkg;

  localparam int TRIG_FRAC_BITS = 14;
  localparam int MW             = 26;        // multiplier operand width
  localparam int PW             = 2 * MW;    // product width
  localparam int PROJ_SHIFT     = 24;
  localparam int Q_SHIFT        = 8;
  localparam int DIV_BITS       = 25;        // quotient bits of 2^24 / z
  localparam int LEVEL_SHIFT    = TRIG_FRAC_BITS - 3;
  localparam logic [3:0] LEVEL_MAX = 4'd11;
  localparam logic [7:0] GLYPH_SPACE = 8'd32;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_PLOT  = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    REG_COS_A  = 4'd0,
    REG_SIN_A  = 4'd1,
    REG_COS_B  = 4'd2,
    REG_SIN_B  = 4'd3,
    REG_TUBE   = 4'd4,
    REG_RING   = 4'd5,
    REG_VIEW   = 4'd6,
    REG_SCALE  = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic [10:0]        cell_index;
    logic signed [15:0] cos_theta;
    logic signed [15:0] sin_theta;
    logic signed [15:0] cos_phi;
    logic signed [15:0] sin_phi;
  } point_t;

  typedef struct packed {
    logic [10:0] target_cell;
    logic [7:0]  glyph;
    logic        stored;
  } result_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CELL, S_RDWAIT, S_MUL, S_WB, S_TEST, S_DIV,
    S_PROBE, S_COMMIT, S_OUT
  } state_e;

  typedef enum logic [4:0] {
    SRC_R1, SRC_CI, SRC_SI, SRC_CJ, SRC_SJ, SRC_CA, SRC_SA, SRC_CB, SRC_SB,
    SRC_CX, SRC_CY, SRC_U1, SRC_U2, SRC_U3, SRC_K1, SRC_OOZ, SRC_Q, SRC_X,
    SRC_Y, SRC_ROW, SRC_COLS
  } src_e;

  typedef enum logic [4:0] {
    WB_CX, WB_CY, WB_U1, WB_U1_ADD, WB_U1_SUB, WB_U2, WB_U3, WB_X, WB_X_SUB,
    WB_Y, WB_Y_ADD, WB_Z, WB_Z_ADD, WB_L, WB_L_ADD, WB_L_SUB, WB_Q, WB_COL,
    WB_ROW, WB_IDX
  } wb_e;

  typedef struct packed {
    src_e a;
    src_e b;
    wb_e  wb;
  } uop_t;

  localparam int NUM_UOPS = 30;
  localparam logic [4:0] UOP_LAST_GEOM = 5'd25;
  localparam logic [4:0] UOP_LAST      = 5'd29;

  function automatic uop_t uop_f(input logic [4:0] step);
    uop_t u;
    u = '{SRC_R1, SRC_CI, WB_CX};
    unique case (step)
      5'd0:  u = '{SRC_R1,  SRC_CI,   WB_CX};
      5'd1:  u = '{SRC_R1,  SRC_SI,   WB_CY};
      5'd2:  u = '{SRC_CB,  SRC_CJ,   WB_U1};
      5'd3:  u = '{SRC_SA,  SRC_SB,   WB_U2};
      5'd4:  u = '{SRC_U2,  SRC_SJ,   WB_U1_ADD};
      5'd5:  u = '{SRC_CA,  SRC_SB,   WB_U3};
      5'd6:  u = '{SRC_CX,  SRC_U1,   WB_X};
      5'd7:  u = '{SRC_CY,  SRC_U3,   WB_X_SUB};
      5'd8:  u = '{SRC_SB,  SRC_CJ,   WB_U1};
      5'd9:  u = '{SRC_SA,  SRC_CB,   WB_U2};
      5'd10: u = '{SRC_U2,  SRC_SJ,   WB_U1_SUB};
      5'd11: u = '{SRC_CA,  SRC_CB,   WB_U3};
      5'd12: u = '{SRC_CX,  SRC_U1,   WB_Y};
      5'd13: u = '{SRC_CY,  SRC_U3,   WB_Y_ADD};
      5'd14: u = '{SRC_CA,  SRC_CX,   WB_U2};
      5'd15: u = '{SRC_U2,  SRC_SJ,   WB_Z};
      5'd16: u = '{SRC_CY,  SRC_SA,   WB_Z_ADD};
      5'd17: u = '{SRC_CJ,  SRC_CI,   WB_U1};
      5'd18: u = '{SRC_U1,  SRC_SB,   WB_L};
      5'd19: u = '{SRC_CA,  SRC_CI,   WB_U1};
      5'd20: u = '{SRC_U1,  SRC_SJ,   WB_L_SUB};
      5'd21: u = '{SRC_SA,  SRC_SI,   WB_L_SUB};
      5'd22: u = '{SRC_CA,  SRC_SI,   WB_U1};
      5'd23: u = '{SRC_CI,  SRC_SA,   WB_U2};
      5'd24: u = '{SRC_U2,  SRC_SJ,   WB_U1_SUB};
      5'd25: u = '{SRC_CB,  SRC_U1,   WB_L_ADD};
      5'd26: u = '{SRC_K1,  SRC_OOZ,  WB_Q};
      5'd27: u = '{SRC_Q,   SRC_X,    WB_COL};
      5'd28: u = '{SRC_Q,   SRC_Y,    WB_ROW};
      5'd29: u = '{SRC_ROW, SRC_COLS, WB_IDX};
      default: u = '{SRC_R1, SRC_CI, WB_CX};
    endcase
    return u;
  endfunction

  function automatic logic [7:0] shade_f(input logic [3:0] lvl);
    logic [7:0] g;
    g = 8'h2E;
    case (lvl)
      4'd0:  g = 8'h2E;  // .
      4'd1:  g = 8'h2C;  // ,
      4'd2:  g = 8'h2D;  // -
      4'd3:  g = 8'h7E;  // ~
      4'd4:  g = 8'h3A;  // :
      4'd5:  g = 8'h3B;  // ;
      4'd6:  g = 8'h3D;  // =
      4'd7:  g = 8'h21;  // !
      4'd8:  g = 8'h2A;  // *
      4'd9:  g = 8'h23;  // #
      4'd10: g = 8'h24;  // $
      default: g = 8'h40;  // @
    endcase
    return g;
  endfunction

endpackage

[rtl/torus_point_zbuffer_plot.sv]
// ----------------------------------------------------------------------------
// torus_point_zbuffer_plot
// Torus point plotter with glyph frame buffer and 1/z depth buffer.
//
//   channel   dir  handshake            beat contents
//   pt        in   pt_valid/pt_ready    point_t: mode, cell, trig values
//   res       out  res_valid/res_ready  result_t: cell, glyph, stored flag
//   cfg       in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Plot: 30 micro-ops on one 26x26 multiplier, each a multiply state and a
// write-back state, with a restoring division for 1/z between the geometry
// and projection micro-ops. Clear passes S_CELL, read S_CELL and S_RDWAIT;
// mode 3 goes straight to S_OUT. Result held until res_ready. After reset
// both buffers are swept, one cell a cycle; pt_ready stays low during the sweep.
// ----------------------------------------------------------------------------
`include "torus_point_zbuffer_plot_macros.svh"

module torus_point_zbuffer_plot #(
  parameter int SCREEN_COLS = 80,
  parameter int SCREEN_ROWS = 24
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            pt_valid,
  output logic            pt_ready,
  input  tpz_pkg::point_t pt,
  output logic            res_valid,
  input  logic            res_ready,
  output tpz_pkg::result_t res,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [3:0]      cfg_index,
  input  logic [15:0]     cfg_data
);
  import tpz_pkg::*;

  localparam int CELLS    = SCREEN_COLS * SCREEN_ROWS;
  localparam int AW       = $clog2(CELLS);
  localparam int VW       = PW + 1;
  localparam int COL_HALF = SCREEN_COLS / 2;
  localparam int ROW_HALF = SCREEN_ROWS / 2;

  // configuration
  logic signed [15:0] cos_a, sin_a, cos_b, sin_b;
  logic [15:0] tube_r, ring_r, view_d, scale_k;

  // item and datapath
  logic [1:0]         mode;
  logic [10:0]        cell_id;
  logic               cell_ok;
  logic signed [15:0] ci, si, cj, sj;
  logic [4:0]         step;
  logic signed [PW-1:0] p;
  logic signed [MW-1:0] cx, cy, u1, u2, u3, x, y, z, lum, q, col, row;
  logic [AW-1:0]      addr;
  logic               idx_ok;
  logic [MW-1:0]      rem;
  logic [DIV_BITS-1:0] quo;
  logic [4:0]         div_cnt;
  logic [AW-1:0]      init_addr;

  // memories
  logic [7:0]  glyph_mem [CELLS];
  logic [15:0] depth_mem [CELLS];
  logic [7:0]  glyph_rd;
  logic [15:0] depth_rd;
  logic        mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]  mem_wglyph;
  logic [15:0] mem_wdepth;

  state_e  state, state_next;
  result_t res_next;
  logic    res_load;
  uop_t    uop;
  logic signed [MW-1:0] opa, opb, tm;
  logic signed [VW-1:0] colv, rowv, colt, rowt, idxs;
  logic [15:0] ooz;
  logic [MW-1:0] rem_sh;
  logic        div_ge;
  logic signed [MW-1:0] lvl_w;
  logic [3:0]  lvl;
  logic [7:0]  shade;

  assign cfg_ready = 1'b1;
  assign res_valid = (state == S_OUT);
  assign uop       = uop_f(step);

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_a   <= 16'sd16384;
      sin_a   <= 16'sd0;
      cos_b   <= 16'sd16384;
      sin_b   <= 16'sd0;
      tube_r  <= 16'd256;
      ring_r  <= 16'd512;
      view_d  <= 16'd1280;
      scale_k <= 16'd12800;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_COS_A: cos_a   <= cfg_data;
        REG_SIN_A: sin_a   <= cfg_data;
        REG_COS_B: cos_b   <= cfg_data;
        REG_SIN_B: sin_b   <= cfg_data;
        REG_TUBE:  tube_r  <= cfg_data;
        REG_RING:  ring_r  <= cfg_data;
        REG_VIEW:  view_d  <= cfg_data;
        REG_SCALE: scale_k <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic signed [MW-1:0] opnd(input src_e s);
    logic signed [MW-1:0] v;
    v = '0;
    unique case (s)
      SRC_R1:   v = MW'(tube_r);
      SRC_CI:   v = MW'(ci);
      SRC_SI:   v = MW'(si);
      SRC_CJ:   v = MW'(cj);
      SRC_SJ:   v = MW'(sj);
      SRC_CA:   v = MW'(cos_a);
      SRC_SA:   v = MW'(sin_a);
      SRC_CB:   v = MW'(cos_b);
      SRC_SB:   v = MW'(sin_b);
      SRC_CX:   v = cx;
      SRC_CY:   v = cy;
      SRC_U1:   v = u1;
      SRC_U2:   v = u2;
      SRC_U3:   v = u3;
      SRC_K1:   v = MW'(scale_k);
      SRC_OOZ:  v = MW'(ooz);
      SRC_Q:    v = q;
      SRC_X:    v = x;
      SRC_Y:    v = y;
      SRC_ROW:  v = row;
      SRC_COLS: v = MW'(SCREEN_COLS);
      default:  v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    opa    = opnd(uop.a);
    opb    = opnd(uop.b);
    tm     = MW'(p >>> TRIG_FRAC_BITS);
    colv   = VW'(p) + (VW'(COL_HALF) <<< PROJ_SHIFT);
    rowv   = (VW'(ROW_HALF) <<< PROJ_SHIFT) - VW'(p);
    colt   = colv + (colv[VW-1] ? VW'((64'd1 << PROJ_SHIFT) - 64'd1) : VW'(0));
    rowt   = rowv + (rowv[VW-1] ? VW'((64'd1 << PROJ_SHIFT) - 64'd1) : VW'(0));
    idxs   = VW'(p) + VW'(col);
    ooz    = (|quo[DIV_BITS-1:16]) ? 16'hFFFF : quo[15:0];
    rem_sh = {rem[MW-2:0], (div_cnt == 5'(DIV_BITS - 1))};
    div_ge = (rem_sh >= $unsigned(z));
    lvl_w  = lum >>> LEVEL_SHIFT;
    lvl    = (lvl_w > MW'(LEVEL_MAX)) ? LEVEL_MAX : lvl_w[3:0];
    shade  = shade_f(lvl);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      glyph_mem[mem_waddr] <= mem_wglyph;
      depth_mem[mem_waddr] <= mem_wdepth;
    end
    glyph_rd <= glyph_mem[mem_raddr];
    depth_rd <= depth_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pt_ready   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = addr;
    mem_raddr  = addr;
    mem_wglyph = GLYPH_SPACE;
    mem_wdepth = '0;
    res_load   = 1'b0;
    res_next   = '0;
    unique case (state)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = init_addr;
        if (init_addr == AW'(CELLS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        pt_ready = 1'b1;
        if (pt_valid) begin
          unique case (pt.mode)
            MODE_PLOT:              state_next = S_MUL;
            MODE_CLEAR, MODE_READ:  state_next = S_CELL;
            default: begin
              res_load   = 1'b1;
              state_next = S_OUT;
            end
          endcase
        end
      end
      S_CELL: begin
        if (!cell_ok) begin
          res_load             = 1'b1;
          res_next.target_cell = cell_id;
          state_next           = S_OUT;
        end else if (mode == MODE_CLEAR) begin
          mem_we     = 1'b1;
          res_load   = 1'b1;
          res_next   = '{cell_id, GLYPH_SPACE, 1'b1};
          state_next = S_OUT;
        end else begin
          state_next = S_RDWAIT;
        end
      end
      S_RDWAIT: begin
        res_load   = 1'b1;
        res_next   = '{cell_id, glyph_rd, 1'b0};
        state_next = S_OUT;
      end
      S_MUL: state_next = S_WB;
      S_WB: begin
        if (step == UOP_LAST_GEOM) state_next = S_TEST;
        else if (step == UOP_LAST) state_next = S_PROBE;
        else state_next = S_MUL;
      end
      S_TEST: begin
        if (z <= 0 || lum <= 0) begin
          res_load   = 1'b1;
          state_next = S_OUT;
        end else begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_cnt == 5'd0) state_next = S_MUL;
      end
      S_PROBE: begin
        if (!idx_ok) begin
          res_load   = 1'b1;
          state_next = S_OUT;
        end else begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        res_load = 1'b1;
        if (ooz > depth_rd) begin
          mem_we     = 1'b1;
          mem_wglyph = shade;
          mem_wdepth = ooz;
          res_next   = '{11'(addr), shade, 1'b1};
        end
        state_next = S_OUT;
      end
      S_OUT: begin
        if (res_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_addr <= '0;
    end else if (state == S_INIT) begin
      init_addr <= init_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) res <= res_next;
    unique case (state)
      S_IDLE: begin
        if (pt_valid) begin
          mode    <= pt.mode;
          cell_id <= pt.cell_index;
          cell_ok <= (32'(pt.cell_index) < CELLS);
          addr    <= AW'(pt.cell_index);
          ci      <= pt.cos_theta;
          si      <= pt.sin_theta;
          cj      <= pt.cos_phi;
          sj      <= pt.sin_phi;
          step    <= '0;
        end
      end
      S_MUL: p <= opa * opb;
      S_WB: begin
        step <= step + 5'd1;
        case (uop.wb)
          WB_CX:     cx  <= MW'(ring_r) + tm;
          WB_CY:     cy  <= tm;
          WB_U1:     u1  <= tm;
          WB_U1_ADD: u1  <= u1 + tm;
          WB_U1_SUB: u1  <= u1 - tm;
          WB_U2:     u2  <= tm;
          WB_U3:     u3  <= tm;
          WB_X:      x   <= tm;
          WB_X_SUB:  x   <= x - tm;
          WB_Y:      y   <= tm;
          WB_Y_ADD:  y   <= y + tm;
          WB_Z:      z   <= MW'(view_d) + tm;
          WB_Z_ADD:  z   <= z + tm;
          WB_L:      lum <= tm;
          WB_L_ADD:  lum <= lum + tm;
          WB_L_SUB:  lum <= lum - tm;
          WB_Q:      q   <= MW'(p >>> Q_SHIFT);
          WB_COL:    col <= MW'(colt >>> PROJ_SHIFT);
          WB_ROW:    row <= MW'(rowt >>> PROJ_SHIFT);
          WB_IDX: begin
            idx_ok <= !idxs[VW-1] && (idxs < VW'(CELLS));
            addr   <= idxs[AW-1:0];
          end
          default: ;
        endcase
      end
      S_TEST: begin
        rem     <= '0;
        quo     <= '0;
        div_cnt <= 5'(DIV_BITS - 1);
      end
      S_DIV: begin
        rem     <= div_ge ? (rem_sh - $unsigned(z)) : rem_sh;
        quo     <= {quo[DIV_BITS-2:0], div_ge};
        div_cnt <= div_cnt - 5'd1;
      end
      default: ;
    endcase
  end

  `TPZ_ASSERT_NOW(a_ready_no_result, clk, rst, pt_ready, !res_valid, "ready while result pending")
  `TPZ_ASSERT_NOW(a_init_blocks, clk, rst, state == S_INIT, !pt_ready && !res_valid, "busy in sweep")
  `TPZ_ASSERT_NOW(a_stored_glyph, clk, rst, res_valid && res.stored, res.glyph != 8'd0, "bad glyph")
  `TPZ_ASSERT_NOW(a_step_range, clk, rst, state == S_MUL, step < 5'(NUM_UOPS), "step overrun")
  `TPZ_ASSERT_NEXT(a_accept_busy, clk, rst, pt_valid && pt_ready, !pt_ready, "double accept")

endmodule
